// ===== rtl/arcsf_pkg.sv =====
package arcsf_pkg;

   localparam int PAYLOAD_BYTES = 7;
   localparam int CMD_BYTES = 7;
   localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
   localparam int FILL_W = $clog2(CMD_BYTES + 1);

   // register indexes on the csr port
   localparam logic [2:0] REG_MAKER_ID = 3'd0;
   localparam logic [2:0] REG_PROTO_VERSION = 3'd1;
   localparam logic [2:0] REG_OWN_DEVICE = 3'd2;
   localparam logic [2:0] REG_ALL_DEVICES = 3'd3;
   localparam logic [2:0] REG_START_CODE = 3'd4;
   localparam logic [2:0] REG_STOP_CODE = 3'd5;
   localparam logic [2:0] REG_MAKER_TYPE = 3'd6;

   localparam logic [1:0] OUT_IGNORED = 2'd0;
   localparam logic [1:0] OUT_STARTED = 2'd1;
   localparam logic [1:0] OUT_STOPPED = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
      logic       cmd;
   } arcsf_req_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic        active_now;
      logic [15:0] session_now;
   } arcsf_rsp_type;

   typedef struct packed {
      logic [15:0] maker_id;
      logic [7:0]  proto_version;
      logic [7:0]  own_device;
      logic [7:0]  all_devices_code;
      logic [7:0]  start_code;
      logic [7:0]  stop_code;
      logic [7:0]  maker_record_type;
   } arcsf_cfg_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic        on;
      logic [15:0] session;
   } arcsf_try_type;

   typedef logic [CMD_BYTES-1:0][7:0] arcsf_cmd_type;

   // checks one 7-byte command against the config and the session state
   function automatic arcsf_try_type try_command(input arcsf_cmd_type b,
                                                 input arcsf_cfg_type cfg,
                                                 input logic on,
                                                 input logic [15:0] ses);
      arcsf_try_type r;
      logic [15:0] new_ses;
      logic hdr_ok;
      r.outcome = OUT_IGNORED;
      r.on = on;
      r.session = ses;
      new_ses = {b[6], b[5]};
      hdr_ok = (b[0] == cfg.maker_id[7:0]) && (b[1] == cfg.maker_id[15:8])
               && (b[2] == cfg.proto_version)
               && ((b[4] == cfg.all_devices_code) || (b[4] == cfg.own_device));
      if (hdr_ok) begin
         if (b[3] == cfg.start_code) begin
            if (!(on && (new_ses == ses))) begin
               r.outcome = OUT_STARTED;
               r.on = 1'b1;
               r.session = new_ses;
            end
         end else if (b[3] == cfg.stop_code) begin
            if (on) begin
               r.outcome = OUT_STOPPED;
               r.on = 1'b0;
               r.session = new_ses;
            end
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/adv_record_command_session_filter_top.sv =====
// the result is registered into the output register on the last byte's transfer
// throughput: one packet byte per cycle; all parsing is one pass of compares per byte
// a last byte waits only while the previous result is still held by a stalled consumer
// reset (synchronous, active high) clears the session state, the packet framing and the
// output valid, and loads the register reset values; no clearing pass is needed
module adv_record_command_session_filter_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  arcsf_pkg::arcsf_req_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output arcsf_pkg::arcsf_rsp_type rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [15:0]             csr_data
);

   localparam logic [1:0] PH_LENGTH = 2'd0;
   localparam logic [1:0] PH_TYPE = 2'd1;
   localparam logic [1:0] PH_VALUE = 2'd2;

   arcsf_pkg::arcsf_cfg_type cfg_ff;

   logic        on_ff, on_in;
   logic [15:0] ses_ff, ses_in;
   logic        in_packet_ff;
   logic        is_write_ff, is_write_in;
   logic [arcsf_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [7:0]  left_ff, left_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  kind_ff, kind_in;
   logic [arcsf_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic        stopped_ff, stopped_in;
   logic        hit_ff, hit_in;
   logic [1:0]  hout_ff, hout_in;
   logic        long_ff, long_in;
   arcsf_pkg::arcsf_cmd_type head_ff, head_in;
   arcsf_pkg::arcsf_cmd_type rec_ff, rec_in;

   logic rsp_valid_ff;
   arcsf_pkg::arcsf_rsp_type rsp_data_ff, rsp_data_in;

   logic accept;
   logic start;
   logic rec_done;
   arcsf_pkg::arcsf_try_type rec_try, head_try;
   logic [7:0] v;

   assign csr_ready = 1'b1;
   // only a result-producing byte has to wait for the output register
   assign req_stall = rsp_valid_ff && rsp_stall && req_data.last_byte;
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign v = req_data.data_byte;
   assign start = req_data.first_byte || !in_packet_ff;

   always_comb begin
      // packet start forces the cleared per-packet state
      is_write_in = start ? req_data.cmd : is_write_ff;
      count_in = start ? '0 : count_ff;
      left_in = start ? 8'd0 : left_ff;
      phase_in = start ? PH_LENGTH : phase_ff;
      kind_in = start ? 8'd0 : kind_ff;
      fill_in = start ? '0 : fill_ff;
      stopped_in = start ? 1'b0 : stopped_ff;
      hit_in = start ? 1'b0 : hit_ff;
      hout_in = start ? arcsf_pkg::OUT_IGNORED : hout_ff;
      long_in = start ? 1'b0 : long_ff;
      head_in = head_ff;
      rec_in = rec_ff;
      rec_done = 1'b0;
      on_in = on_ff;
      ses_in = ses_ff;

      for (int i = 0; i < arcsf_pkg::CMD_BYTES; i++) begin
         if (count_in == arcsf_pkg::CNT_W'(i)) begin
            head_in[i] = v;
         end
      end
      if (count_in < arcsf_pkg::CNT_W'(arcsf_pkg::PAYLOAD_BYTES)) begin
         count_in = count_in + 1'b1;
      end

      if (!is_write_in && !stopped_in && !hit_in) begin
         unique case (phase_in)
            PH_LENGTH: begin
               if (v == 8'd0) begin
                  stopped_in = 1'b1;
               end else begin
                  left_in = v - 8'd1;
                  long_in = 9'(v) >= 9'(arcsf_pkg::PAYLOAD_BYTES + 1);
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               kind_in = v;
               fill_in = '0;
               if (left_in == 8'd0) begin
                  rec_done = 1'b1;
               end else begin
                  phase_in = PH_VALUE;
               end
            end
            default: begin
               for (int i = 0; i < arcsf_pkg::CMD_BYTES; i++) begin
                  if (fill_in == arcsf_pkg::FILL_W'(i)) begin
                     rec_in[i] = v;
                  end
               end
               if (fill_in < arcsf_pkg::FILL_W'(arcsf_pkg::CMD_BYTES)) begin
                  fill_in = fill_in + 1'b1;
               end
               left_in = left_in - 8'd1;
               if (left_in == 8'd0) begin
                  rec_done = 1'b1;
               end
            end
         endcase
      end

      rec_try = arcsf_pkg::try_command(rec_in, cfg_ff, on_ff, ses_ff);
      head_try = arcsf_pkg::try_command(head_in, cfg_ff, on_ff, ses_ff);

      if (rec_done) begin
         phase_in = PH_LENGTH;
         if ((kind_in == cfg_ff.maker_record_type) && long_in
             && (rec_try.outcome != arcsf_pkg::OUT_IGNORED)) begin
            hit_in = 1'b1;
            hout_in = rec_try.outcome;
            on_in = rec_try.on;
            ses_in = rec_try.session;
         end
      end

      rsp_data_in.outcome = hout_in;
      // raw try of the packet head when no record was taken
      if (req_data.last_byte && !hit_in
          && (count_in >= arcsf_pkg::CNT_W'(arcsf_pkg::PAYLOAD_BYTES))) begin
         rsp_data_in.outcome = head_try.outcome;
         on_in = head_try.on;
         ses_in = head_try.session;
      end
      rsp_data_in.active_now = on_in;
      rsp_data_in.session_now = ses_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.maker_id <= 16'd0;
         cfg_ff.proto_version <= 8'd0;
         cfg_ff.own_device <= 8'd0;
         cfg_ff.all_devices_code <= 8'd255;
         cfg_ff.start_code <= 8'd1;
         cfg_ff.stop_code <= 8'd2;
         cfg_ff.maker_record_type <= 8'd255;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            arcsf_pkg::REG_MAKER_ID: cfg_ff.maker_id <= csr_data;
            arcsf_pkg::REG_PROTO_VERSION: cfg_ff.proto_version <= csr_data[7:0];
            arcsf_pkg::REG_OWN_DEVICE: cfg_ff.own_device <= csr_data[7:0];
            arcsf_pkg::REG_ALL_DEVICES: cfg_ff.all_devices_code <= csr_data[7:0];
            arcsf_pkg::REG_START_CODE: cfg_ff.start_code <= csr_data[7:0];
            arcsf_pkg::REG_STOP_CODE: cfg_ff.stop_code <= csr_data[7:0];
            arcsf_pkg::REG_MAKER_TYPE: cfg_ff.maker_record_type <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff <= 1'b0;
         ses_ff <= 16'd0;
         in_packet_ff <= 1'b0;
      end else if (accept) begin
         on_ff <= on_in;
         ses_ff <= ses_in;
         in_packet_ff <= !req_data.last_byte;
      end
   end

   // per-packet state; a new packet overrides it, so no reset is needed
   always_ff @(posedge clock) begin
      if (accept) begin
         is_write_ff <= is_write_in;
         count_ff <= count_in;
         left_ff <= left_in;
         phase_ff <= phase_in;
         kind_ff <= kind_in;
         fill_ff <= fill_in;
         stopped_ff <= stopped_in;
         hit_ff <= hit_in;
         hout_ff <= hout_in;
         long_ff <= long_in;
         head_ff <= head_in;
         rec_ff <= rec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_data.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.last_byte) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.outcome != 2'd3))
      else $error("undefined outcome code");

   a_started_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.outcome == arcsf_pkg::OUT_STARTED)
      |-> rsp_data_ff.active_now)
      else $error("start result without active measurement");

   a_stopped_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.outcome == arcsf_pkg::OUT_STOPPED)
      |-> !rsp_data_ff.active_now)
      else $error("stop result with active measurement");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_byte |=> rsp_valid_ff && !in_packet_ff)
      else $error("last byte transfer did not close the packet with a result");

endmodule

// ===== tb/cmd_filter_checker.sv =====
module cmd_filter_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  arcsf_pkg::arcsf_req_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  arcsf_pkg::arcsf_rsp_type rsp_data,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [15:0]              csr_data,
   output int                       fail_count,
   output int                       pending
);

   typedef enum logic [1:0] {WANT_LEN, WANT_TYPE, WANT_VALUE} walk_phase_type;

   arcsf_pkg::arcsf_cfg_type cfg;
   logic          meas_on;
   logic [15:0]   cur_ses;
   arcsf_pkg::arcsf_cmd_type head_buf;
   arcsf_pkg::arcsf_cmd_type rec_buf;
   int            pkt_cnt;
   int            rec_fill;
   logic [7:0]    rec_left;
   logic [7:0]    rec_kind;
   walk_phase_type phase;
   logic          walk_done;
   logic          found;
   logic [1:0]    found_outcome;
   logic          in_pkt;
   logic          is_write;
   logic          rec_long;
   arcsf_pkg::arcsf_rsp_type outcome_due[$];
   arcsf_pkg::arcsf_rsp_type oldest;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic void clear_packet();
      pkt_cnt = 0;
      rec_left = '0;
      phase = WANT_LEN;
      rec_kind = '0;
      rec_fill = 0;
      walk_done = 1'b0;
      found = 1'b0;
      found_outcome = arcsf_pkg::OUT_IGNORED;
      in_pkt = 1'b0;
      is_write = 1'b0;
      rec_long = 1'b0;
   endfunction

   // checks a 7-byte command and updates the session state when it is taken
   function automatic logic [1:0] apply_command(input arcsf_pkg::arcsf_cmd_type b);
      logic [15:0] ses;
      ses = {b[6], b[5]};
      if ({b[1], b[0]} != cfg.maker_id || b[2] != cfg.proto_version)
         return arcsf_pkg::OUT_IGNORED;
      if (b[4] != cfg.all_devices_code && b[4] != cfg.own_device)
         return arcsf_pkg::OUT_IGNORED;
      if (b[3] == cfg.start_code) begin
         if (meas_on && ses == cur_ses)
            return arcsf_pkg::OUT_IGNORED;
         meas_on = 1'b1;
         cur_ses = ses;
         return arcsf_pkg::OUT_STARTED;
      end
      if (b[3] == cfg.stop_code && meas_on) begin
         meas_on = 1'b0;
         cur_ses = ses;
         return arcsf_pkg::OUT_STOPPED;
      end
      return arcsf_pkg::OUT_IGNORED;
   endfunction

   function automatic void close_record();
      logic [1:0] res;
      phase = WANT_LEN;
      if (rec_kind == cfg.maker_record_type && rec_long) begin
         res = apply_command(rec_buf);
         if (res != arcsf_pkg::OUT_IGNORED) begin
            found = 1'b1;
            found_outcome = res;
         end
      end
   endfunction

   function automatic void walk_byte(input logic [7:0] v);
      if (walk_done || found)
         return;
      case (phase)
         WANT_LEN: begin
            if (v == 8'd0) begin
               walk_done = 1'b1;
            end else begin
               rec_left = v - 8'd1;
               rec_long = (int'(v) - 1) >= arcsf_pkg::PAYLOAD_BYTES;
               phase = WANT_TYPE;
            end
         end
         WANT_TYPE: begin
            rec_kind = v;
            rec_fill = 0;
            if (rec_left == 8'd0)
               close_record();
            else
               phase = WANT_VALUE;
         end
         default: begin
            // value bytes past the command are counted but not kept
            if (rec_fill < arcsf_pkg::CMD_BYTES) begin
               rec_buf[rec_fill] = v;
               rec_fill++;
            end
            rec_left = rec_left - 8'd1;
            if (rec_left == 8'd0)
               close_record();
         end
      endcase
   endfunction

   function automatic void track_packet_byte(input arcsf_pkg::arcsf_req_type item);
      arcsf_pkg::arcsf_rsp_type due;
      // a first flag, or any byte after a last byte, opens a new packet
      if (item.first_byte || !in_pkt) begin
         clear_packet();
         in_pkt = 1'b1;
         is_write = item.cmd;
      end
      if (pkt_cnt < arcsf_pkg::CMD_BYTES)
         head_buf[pkt_cnt] = item.data_byte;
      if (pkt_cnt < arcsf_pkg::PAYLOAD_BYTES)
         pkt_cnt++;
      if (!is_write)
         walk_byte(item.data_byte);
      if (item.last_byte) begin
         due.outcome = found_outcome;
         if (!found && pkt_cnt >= arcsf_pkg::PAYLOAD_BYTES)
            due.outcome = apply_command(head_buf);
         due.active_now = meas_on;
         due.session_now = cur_ses;
         outcome_due.push_back(due);
         clear_packet();
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.maker_id = 16'd0;
         cfg.proto_version = 8'd0;
         cfg.own_device = 8'd0;
         cfg.all_devices_code = 8'd255;
         cfg.start_code = 8'd1;
         cfg.stop_code = 8'd2;
         cfg.maker_record_type = 8'd255;
         meas_on = 1'b0;
         cur_ses = 16'd0;
         clear_packet();
         outcome_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               arcsf_pkg::REG_MAKER_ID:      cfg.maker_id = csr_data;
               arcsf_pkg::REG_PROTO_VERSION: cfg.proto_version = csr_data[7:0];
               arcsf_pkg::REG_OWN_DEVICE:    cfg.own_device = csr_data[7:0];
               arcsf_pkg::REG_ALL_DEVICES:   cfg.all_devices_code = csr_data[7:0];
               arcsf_pkg::REG_START_CODE:    cfg.start_code = csr_data[7:0];
               arcsf_pkg::REG_STOP_CODE:     cfg.stop_code = csr_data[7:0];
               arcsf_pkg::REG_MAKER_TYPE:    cfg.maker_record_type = csr_data[7:0];
               default: ;
            endcase
         end
         // compare before predicting so a stray result never takes a fresh entry
         if (rsp_valid && !rsp_stall) begin
            if (outcome_due.size() == 0) begin
               $error("unexpected result: outcome %0d active_now %0d session_now %0h",
                      rsp_data.outcome, rsp_data.active_now, rsp_data.session_now);
               fail_count++;
            end else begin
               oldest = outcome_due.pop_front();
               if (rsp_data.outcome !== oldest.outcome) begin
                  $error("outcome: expected %0d, got %0d", oldest.outcome, rsp_data.outcome);
                  fail_count++;
               end
               if (rsp_data.active_now !== oldest.active_now) begin
                  $error("active_now: expected %0d, got %0d",
                         oldest.active_now, rsp_data.active_now);
                  fail_count++;
               end
               if (rsp_data.session_now !== oldest.session_now) begin
                  $error("session_now: expected %0h, got %0h",
                         oldest.session_now, rsp_data.session_now);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            track_packet_byte(req_data);
      end
      pending = outcome_due.size();
   end

endmodule

// ===== tb/testbench.sv =====
module testbench;

   localparam int BYTE_BUDGET = 1200;
   localparam int NUM_PHASES = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   arcsf_pkg::arcsf_req_type req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   arcsf_pkg::arcsf_rsp_type rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   logic [2:0]    csr_index;
   logic [15:0]   csr_data;
   int            fail_count;
   int            pending;

   bit            no_idle;
   arcsf_pkg::arcsf_cfg_type cfg_now;
   logic [7:0]    frame[$];
   int            sent_bytes;
   int            idle_cycles;

   adv_record_command_session_filter_top u_dut (.*);

   cmd_filter_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // no transfer of any kind for too long means the block is hung
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // result side: after each transfer, stall for a random number of cycles
   initial begin : result_side
      int hold;
      rsp_stall = 1'b0;
      forever begin
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         hold = no_idle ? 0 : $urandom_range(0, 8);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic push_byte(input arcsf_pkg::arcsf_req_type item);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // sends frame bytes 0 .. stop_at-1; stopping short abandons the packet
   task automatic send_packet(input bit wr, input bit drop_first, input int stop_at);
      arcsf_pkg::arcsf_req_type item;
      int i;
      for (i = 0; i < stop_at; i++) begin
         item.data_byte = frame[i];
         item.first_byte = (i == 0) && !drop_first;
         item.last_byte = (i == frame.size() - 1);
         item.cmd = (i == 0) ? wr : 1'($urandom_range(0, 1));
         push_byte(item);
      end
      sent_bytes += stop_at;
   endtask

   // wait until every result is back and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_config(input arcsf_pkg::arcsf_cfg_type c);
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      write_reg(arcsf_pkg::REG_MAKER_ID, c.maker_id);
      // upper bits of the 8-bit registers are don't-care
      write_reg(arcsf_pkg::REG_PROTO_VERSION, {junk, c.proto_version});
      write_reg(arcsf_pkg::REG_OWN_DEVICE, {~junk, c.own_device});
      write_reg(arcsf_pkg::REG_ALL_DEVICES, {junk, c.all_devices_code});
      write_reg(arcsf_pkg::REG_START_CODE, {~junk, c.start_code});
      write_reg(arcsf_pkg::REG_STOP_CODE, {junk, c.stop_code});
      write_reg(arcsf_pkg::REG_MAKER_TYPE, {~junk, c.maker_record_type});
      write_reg(REG_UNUSED, {junk, ~junk});
      csr_valid <= 1'b0;
      cfg_now = c;
   endtask

   // mostly well-formed command, with each check broken now and then
   function automatic void add_command();
      logic [15:0] maker;
      logic [15:0] ses;
      logic [7:0]  ver;
      logic [7:0]  op;
      logic [7:0]  dev;
      maker = ($urandom_range(0, 9) < 8) ? cfg_now.maker_id : 16'($urandom_range(0, 65535));
      ver = ($urandom_range(0, 9) < 8) ? cfg_now.proto_version : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 4))
         0, 1:    op = cfg_now.start_code;
         2, 3:    op = cfg_now.stop_code;
         default: op = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 3))
         0, 1:    dev = cfg_now.own_device;
         2:       dev = cfg_now.all_devices_code;
         default: dev = 8'($urandom_range(0, 255));
      endcase
      // a small session pool so repeated starts hit the same session
      case ($urandom_range(0, 3))
         0:       ses = 16'h0000;
         1:       ses = 16'hffff;
         2:       ses = 16'($urandom_range(0, 3));
         default: ses = 16'($urandom_range(0, 65535));
      endcase
      frame.push_back(maker[7:0]);
      frame.push_back(maker[15:8]);
      frame.push_back(ver);
      frame.push_back(op);
      frame.push_back(dev);
      frame.push_back(ses[7:0]);
      frame.push_back(ses[15:8]);
   endfunction

   function automatic void add_junk(input int n);
      repeat (n) frame.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void add_maker_record();
      int len;
      len = $urandom_range(8, 11);
      frame.push_back(8'(len));
      frame.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : cfg_now.maker_record_type);
      add_command();
      add_junk(len - 8);
   endfunction

   function automatic void add_filler();
      int len;
      len = $urandom_range(1, 4);
      frame.push_back(8'(len));
      frame.push_back(($urandom_range(0, 3) == 0) ? cfg_now.maker_record_type
                                                  : 8'($urandom_range(0, 255)));
      add_junk(len - 1);
   endfunction

   task automatic send_random_packet();
      int  kind;
      int  len;
      int  stop_at;
      bit  wr;
      bit  drop_first;
      frame.delete();
      wr = 1'b0;
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
         wr = 1'b1;
         add_command();
         add_junk($urandom_range(0, 3));
         if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 6);
            while (frame.size() > len) frame.delete(frame.size() - 1);
         end
      end else if (kind < 70) begin
         repeat ($urandom_range(0, 2)) add_filler();
         if ($urandom_range(0, 5) == 0) begin
            // maker record too short to hold a command
            len = $urandom_range(1, 7);
            frame.push_back(8'(len));
            frame.push_back(cfg_now.maker_record_type);
            add_junk(len - 1);
         end else begin
            add_maker_record();
         end
         if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1) == 0)
               add_filler();
            else
               add_maker_record();
         end
         case ($urandom_range(0, 5))
            0: begin
               frame.push_back(8'd0);
               add_junk($urandom_range(0, 3));
            end
            1: begin
               // record cut off by the end of the packet
               len = $urandom_range(2, 12);
               frame.push_back(8'(len));
               frame.push_back(cfg_now.maker_record_type);
               add_junk($urandom_range(0, len - 2));
            end
            2: begin
               frame.push_back(8'd0);
               add_maker_record();
            end
            default: ;
         endcase
      end else if (kind < 85) begin
         add_command();
         add_junk($urandom_range(0, 2));
      end else if (kind < 98) begin
         wr = 1'($urandom_range(0, 1));
         add_junk($urandom_range(1, 20));
      end else begin
         // longest record the length byte allows
         frame.push_back(8'd255);
         frame.push_back(cfg_now.maker_record_type);
         add_command();
         add_junk(247);
      end
      drop_first = ($urandom_range(0, 11) == 0);
      stop_at = frame.size();
      if (stop_at > 1 && $urandom_range(0, 19) == 0)
         stop_at = $urandom_range(1, stop_at - 1);
      send_packet(wr, drop_first, stop_at);
   endtask

   function automatic arcsf_pkg::arcsf_cfg_type pick_config(input int phase);
      arcsf_pkg::arcsf_cfg_type c;
      case (phase)
         1:       c = '0;
         2:       c = '1;
         default: begin
            c.maker_id = 16'($urandom_range(0, 65535));
            c.proto_version = 8'($urandom_range(0, 255));
            c.own_device = 8'($urandom_range(0, 255));
            c.all_devices_code = 8'($urandom_range(0, 255));
            c.start_code = 8'($urandom_range(0, 255));
            c.stop_code = 8'($urandom_range(0, 255));
            c.maker_record_type = 8'($urandom_range(0, 255));
         end
      endcase
      return c;
   endfunction

   initial begin : stimulus
      int phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      no_idle = 1'b0;
      sent_bytes = 0;
      idle_cycles = 0;
      cfg_now.maker_id = 16'd0;
      cfg_now.proto_version = 8'd0;
      cfg_now.own_device = 8'd0;
      cfg_now.all_devices_code = 8'd255;
      cfg_now.start_code = 8'd1;
      cfg_now.stop_code = 8'd2;
      cfg_now.maker_record_type = 8'd255;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // raw write start to every node, session zero
      frame = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hff, 8'h00, 8'h00};
      send_packet(1'b1, 1'b0, frame.size());
      // one-byte packet
      frame = '{8'hff};
      send_packet(1'b0, 1'b0, frame.size());
      // maker record stopping from own device, session ffff
      frame = '{8'h08, 8'hff, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'hff, 8'hff};
      send_packet(1'b0, 1'b0, frame.size());
      // stop while idle, packet opened without a first flag
      frame = '{8'h00, 8'h00, 8'h00, 8'h02, 8'hff, 8'h34, 8'h12};
      send_packet(1'b1, 1'b1, frame.size());
      frame = '{8'h00};
      send_packet(1'b1, 1'b0, frame.size());
      settle();

      sent_bytes = 0;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         program_config(pick_config(phase));
         no_idle = (phase == 1) || ($urandom_range(0, 3) == 0);
         while (sent_bytes < (phase + 1) * BYTE_BUDGET / NUM_PHASES) begin
            send_random_packet();
            if ($urandom_range(0, 19) == 0)
               settle();
         end
         settle();
      end

      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
